// File: sv/perspective_correct_attribute_interp_core_macros.svh
// Assertion macros shared by the perspective-correct interpolator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PERSPECTIVE_CORRECT_ATTRIBUTE_INTERP_CORE_MACROS_SVH
`define PERSPECTIVE_CORRECT_ATTRIBUTE_INTERP_CORE_MACROS_SVH
`ifndef SYNTH
`define PCAI_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define PCAI_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PCAI_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define PCAI_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

// File: sv/pcai_pkg.sv
// Types and constants of the perspective-correct attribute interpolator.
// No dependencies; used by every module of the block.
package pcai_pkg;

  localparam int ATTR_W  = 24;
  localparam int DEPTH_W = 32;
  localparam int BARY_W  = 17;
  localparam int ZZ_W    = 64;   // product of two depths
  localparam int P_W     = 81;   // depth product times weight
  localparam int D_W     = 83;   // perspective denominator
  localparam int CHUNK_W = 27;   // slice of P_W fed to one multiplier
  localparam int PART_W  = CHUNK_W + ATTR_W;
  localparam int T_W     = 104;  // numerator term
  localparam int N_W     = 106;  // numerator sum
  localparam int NUM_W   = 108;  // 2*|N| + D
  localparam int DEN_W   = 84;   // 2*D
  localparam int QW      = 25;   // quotient bits, top bit flags overflow
  localparam int PP_W    = 41;   // plain path product
  localparam int PS_W    = 43;   // plain path sum
  localparam int PR_W    = 28;   // plain path rounded magnitude
  localparam int ONE_SHIFT = 16;

  localparam logic [QW-1:0] OUT_MAX_POS = QW'(8388607);
  localparam logic [QW-1:0] OUT_MAX_NEG = QW'(8388608);

  typedef struct packed {
    logic [2:0][BARY_W-1:0]  bary;
    logic [2:0][DEPTH_W-1:0] depth;
    logic [2:0][ATTR_W-1:0]  attr;
  } item_t;

  typedef struct packed {
    logic              bypass;
    logic [ATTR_W-1:0] byp_value;
    logic              byp_sat;
    logic              byp_deg;
    logic              neg;
  } side_t;

endpackage

// File: sv/perspective_correct_attribute_interp_core.sv
// Top level of the perspective-correct attribute interpolator.
// Depends on pcai_pkg, pcai_front, pcai_div_step and the assertion macros header.
//
//   channel | ports                         | payload
//   --------+-------------------------------+---------------------------------
//   input   | in_tvalid in_tready in_tdata  | three attrs, depths, weights
//   result  | out_tvalid out_tready out_... | interp_value, flags in tuser
//
// One item enters per cycle while in_tready is high and passes through eight
// multiply and accumulate stages, 25 restoring-division stages (one quotient bit
// per stage, each a 109-bit compare and subtract) and the output register.
// The whole pipeline advances together; when the output register holds an
// item that is not taken, every stage holds and in_tready drops.
// Synchronous active-low reset clears only the valid bits.
`include "perspective_correct_attribute_interp_core_macros.svh"
module perspective_correct_attribute_interp_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // attr_a[23:0] attr_b[47:24] attr_c[71:48] depth_a[103:72] depth_b[135:104]
  // depth_c[167:136] bary_a[184:168] bary_b[201:185] bary_c[218:202], zero fill
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // interp_value[23:0]
  output logic [23:0]  out_tdata,
  // was_saturated[0] degenerate[1]
  output logic [1:0]   out_tuser
);
  import pcai_pkg::*;

  localparam int STEPS = QW;

  logic  en;
  item_t item;

  logic             f_valid;
  logic [NUM_W-1:0] f_num;
  logic [DEN_W-1:0] f_den;
  side_t            f_side;

  logic [STEPS:0]            s_valid;
  logic [STEPS:0][NUM_W-1:0] s_rem;
  logic [STEPS:0][DEN_W-1:0] s_den;
  logic [STEPS:0][QW-1:0]    s_q;
  side_t [STEPS:0]           s_side;

  logic              out_valid_r;
  logic [ATTR_W-1:0] out_value_r, out_value_nxt;
  logic              out_sat_r, out_sat_nxt;
  logic              out_deg_r, out_deg_nxt;

  logic [QW-1:0]     q_fin, lim;
  logic              neg_eff;
  logic [ATTR_W-1:0] m;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Unpack the input item.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item.attr[i]  = in_tdata[i*ATTR_W +: ATTR_W];
      item.depth[i] = in_tdata[3*ATTR_W + i*DEPTH_W +: DEPTH_W];
      item.bary[i]  = in_tdata[3*ATTR_W + 3*DEPTH_W + i*BARY_W +: BARY_W];
    end
  end

  pcai_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_item   (item),
    .out_valid (f_valid),
    .out_num   (f_num),
    .out_den   (f_den),
    .out_side  (f_side)
  );

  assign s_valid[0] = f_valid;
  assign s_rem[0]   = f_num;
  assign s_den[0]   = f_den;
  assign s_q[0]     = '0;
  assign s_side[0]  = f_side;

  // Quotient bit 24 first: if it is set the result saturates whatever the
  // remaining bits are, so the chain never needs more than 25 steps.
  for (genvar k = 0; k < STEPS; k++) begin : g_div
    pcai_div_step #(.SHIFT(STEPS - 1 - k)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (s_valid[k]),
      .in_rem    (s_rem[k]),
      .in_den    (s_den[k]),
      .in_q      (s_q[k]),
      .in_side   (s_side[k]),
      .out_valid (s_valid[k+1]),
      .out_rem   (s_rem[k+1]),
      .out_den   (s_den[k+1]),
      .out_q     (s_q[k+1]),
      .out_side  (s_side[k+1])
    );
  end

  // Final sign, saturation and bypass selection.
  assign q_fin   = s_q[STEPS];
  assign neg_eff = s_side[STEPS].neg && (q_fin != '0);
  assign lim     = neg_eff ? OUT_MAX_NEG : OUT_MAX_POS;

  always_comb begin
    m = (q_fin > lim) ? lim[ATTR_W-1:0] : q_fin[ATTR_W-1:0];
    if (s_side[STEPS].bypass) begin
      out_value_nxt = s_side[STEPS].byp_value;
      out_sat_nxt   = s_side[STEPS].byp_sat;
      out_deg_nxt   = s_side[STEPS].byp_deg;
    end else begin
      out_value_nxt = neg_eff ? (ATTR_W'(0) - m) : m;
      out_sat_nxt   = q_fin > lim;
      out_deg_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= out_value_nxt;
      out_sat_r   <= out_sat_nxt;
      out_deg_r   <= out_deg_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_deg_r, out_sat_r};

  // A degenerate item carries a zero value and is never flagged saturated.
  `PCAI_ASSERT_IMP(a_deg_zero, clk, rst_n, out_valid_r && out_deg_r,
                   (out_value_r == '0) && !out_sat_r)
  // A saturated value sits at one of the two range ends.
  `PCAI_ASSERT_IMP(a_sat_end, clk, rst_n, out_valid_r && out_sat_r,
                   (out_value_r == 24'h7FFFFF) || (out_value_r == 24'h800000))
  // An item leaving the divider chain while stalled stays there.
  `PCAI_ASSERT_NEXT(a_hold, clk, rst_n, s_valid[STEPS] && !en, s_valid[STEPS])

endmodule

// File: sv/pcai_front.sv
// Multiply and accumulate stages: forms numerator 2|N|+D and divisor 2D,
// and resolves the equal-depth and zero-denominator cases. Uses pcai_pkg.
module pcai_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  pcai_pkg::item_t           in_item,
  output logic                      out_valid,
  output logic [pcai_pkg::NUM_W-1:0] out_num,
  output logic [pcai_pkg::DEN_W-1:0] out_den,
  output pcai_pkg::side_t           out_side
);
  import pcai_pkg::*;

  // stage 1
  logic                     v1_r, eq1_r;
  logic [2:0]               cneg1_r;
  logic [2:0][ATTR_W-1:0]   cmag1_r;
  logic [2:0][DEPTH_W-1:0]  z1_r;
  logic [2:0][BARY_W-1:0]   w1_r;
  // stage 2
  logic                     v2_r, eq2_r;
  logic [2:0]               cneg2_r;
  logic [2:0][ATTR_W-1:0]   cmag2_r;
  logic [2:0][BARY_W-1:0]   w2_r;
  logic [2:0][ZZ_W-1:0]     zz2_r;
  logic [2:0][PP_W-1:0]     pp2_r;
  // stage 3
  logic                     v3_r, eq3_r;
  logic [2:0]               cneg3_r;
  logic [2:0][ATTR_W-1:0]   cmag3_r;
  logic [2:0][P_W-1:0]      p3_r;
  logic [PS_W-1:0]          ppos3_r, pneg3_r;
  // stage 4
  logic                     v4_r, eq4_r, pn4_r;
  logic [2:0]               cneg4_r;
  logic [2:0][2:0][PART_W-1:0] part4_r;
  logic [D_W-1:0]           d4_r;
  logic [PR_W-1:0]          pr4_r;
  // stage 5
  logic                     v5_r, eq5_r, psat5_r;
  logic [2:0]               cneg5_r;
  logic [2:0][T_W-1:0]      t5_r;
  logic [D_W-1:0]           d5_r;
  logic [ATTR_W-1:0]        pval5_r;
  // stage 6
  logic                     v6_r, eq6_r, psat6_r;
  logic [N_W-1:0]           npos6_r, nneg6_r;
  logic [D_W-1:0]           d6_r;
  logic [ATTR_W-1:0]        pval6_r;
  // stage 7
  logic                     v7_r;
  logic [N_W-1:0]           mag7_r;
  logic [D_W-1:0]           d7_r;
  side_t                    side7_r;
  // stage 8
  logic                     v8_r;
  logic [NUM_W-1:0]         num8_r;
  logic [DEN_W-1:0]         den8_r;
  side_t                    side8_r;

  // combinational helpers
  logic [PS_W-1:0]  ppos_nxt, pneg_nxt, pdiff;
  logic             pn_nxt;
  logic [PS_W:0]    pround;
  logic             sneg;
  logic [PR_W-1:0]  plim;
  logic             psat_nxt;
  logic [ATTR_W-1:0] pm, pval_nxt;
  logic [N_W-1:0]   npos_nxt, nneg_nxt;
  logic [N_W:0]     ndiff;
  side_t            side7_nxt;

  always_comb begin
    ppos_nxt = '0;
    pneg_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (cneg2_r[i]) pneg_nxt = pneg_nxt + PS_W'(pp2_r[i]);
      else            ppos_nxt = ppos_nxt + PS_W'(pp2_r[i]);
    end
  end

  // plain path: sign, magnitude and round half away from zero
  assign pn_nxt = pneg3_r > ppos3_r;
  assign pdiff  = pn_nxt ? (pneg3_r - ppos3_r) : (ppos3_r - pneg3_r);
  assign pround = {1'b0, pdiff} + (PS_W+1)'(1 << (ONE_SHIFT - 1));

  assign sneg     = pn4_r && (pr4_r != '0);
  assign plim     = sneg ? PR_W'(OUT_MAX_NEG) : PR_W'(OUT_MAX_POS);
  assign psat_nxt = pr4_r > plim;
  assign pm       = psat_nxt ? plim[ATTR_W-1:0] : pr4_r[ATTR_W-1:0];
  assign pval_nxt = sneg ? (ATTR_W'(0) - pm) : pm;

  always_comb begin
    npos_nxt = '0;
    nneg_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (cneg5_r[i]) nneg_nxt = nneg_nxt + N_W'(t5_r[i]);
      else            npos_nxt = npos_nxt + N_W'(t5_r[i]);
    end
  end

  assign ndiff = {1'b0, npos6_r} - {1'b0, nneg6_r};

  always_comb begin
    side7_nxt.neg       = ndiff[N_W];
    side7_nxt.bypass    = eq6_r || (d6_r == '0);
    side7_nxt.byp_value = eq6_r ? pval6_r : '0;
    side7_nxt.byp_sat   = eq6_r ? psat6_r : 1'b0;
    side7_nxt.byp_deg   = !eq6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r;     v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cneg1_r[i] <= in_item.attr[i][ATTR_W-1];
        cmag1_r[i] <= in_item.attr[i][ATTR_W-1] ? (ATTR_W'(0) - in_item.attr[i])
                                                  : in_item.attr[i];
        z1_r[i]    <= in_item.depth[i];
        w1_r[i]    <= in_item.bary[i];
      end
      eq1_r <= (in_item.depth[0] == in_item.depth[1]) &&
               (in_item.depth[1] == in_item.depth[2]);

      zz2_r[0] <= z1_r[1] * z1_r[2];
      zz2_r[1] <= z1_r[0] * z1_r[2];
      zz2_r[2] <= z1_r[0] * z1_r[1];
      for (int i = 0; i < 3; i++) begin
        pp2_r[i] <= PP_W'(cmag1_r[i]) * PP_W'(w1_r[i]);
      end
      cneg2_r <= cneg1_r; cmag2_r <= cmag1_r; w2_r <= w1_r; eq2_r <= eq1_r;

      for (int i = 0; i < 3; i++) begin
        p3_r[i] <= P_W'(zz2_r[i]) * P_W'(w2_r[i]);
      end
      ppos3_r <= ppos_nxt; pneg3_r <= pneg_nxt;
      cneg3_r <= cneg2_r; cmag3_r <= cmag2_r; eq3_r <= eq2_r;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          part4_r[i][j] <= PART_W'(p3_r[i][j*CHUNK_W +: CHUNK_W]) * PART_W'(cmag3_r[i]);
        end
      end
      d4_r    <= D_W'(p3_r[0]) + D_W'(p3_r[1]) + D_W'(p3_r[2]);
      pn4_r   <= pn_nxt;
      pr4_r   <= pround[PS_W:ONE_SHIFT];
      cneg4_r <= cneg3_r; eq4_r <= eq3_r;

      for (int i = 0; i < 3; i++) begin
        t5_r[i] <= T_W'(part4_r[i][0]) + (T_W'(part4_r[i][1]) << CHUNK_W)
                 + (T_W'(part4_r[i][2]) << (2 * CHUNK_W));
      end
      d5_r <= d4_r; psat5_r <= psat_nxt; pval5_r <= pval_nxt;
      cneg5_r <= cneg4_r; eq5_r <= eq4_r;

      npos6_r <= npos_nxt; nneg6_r <= nneg_nxt;
      d6_r <= d5_r; psat6_r <= psat5_r; pval6_r <= pval5_r; eq6_r <= eq5_r;

      mag7_r  <= ndiff[N_W] ? (N_W'(0) - ndiff[N_W-1:0]) : ndiff[N_W-1:0];
      d7_r    <= d6_r;
      side7_r <= side7_nxt;

      num8_r  <= {1'b0, mag7_r, 1'b0} + NUM_W'(d7_r);
      den8_r  <= {d7_r, 1'b0};
      side8_r <= side7_r;
    end
  end

  assign out_valid = v8_r;
  assign out_num   = num8_r;
  assign out_den   = den8_r;
  assign out_side  = side8_r;

endmodule

// File: sv/pcai_div_step.sv
// One registered restoring-division step: yields one quotient bit.
// Uses pcai_pkg; instantiated in a chain by the top level.
module pcai_div_step #(
  parameter int SHIFT = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [pcai_pkg::NUM_W-1:0] in_rem,
  input  logic [pcai_pkg::DEN_W-1:0] in_den,
  input  logic [pcai_pkg::QW-1:0]    in_q,
  input  pcai_pkg::side_t            in_side,
  output logic                       out_valid,
  output logic [pcai_pkg::NUM_W-1:0] out_rem,
  output logic [pcai_pkg::DEN_W-1:0] out_den,
  output logic [pcai_pkg::QW-1:0]    out_q,
  output pcai_pkg::side_t            out_side
);
  import pcai_pkg::*;

  logic [NUM_W:0]   trial, rem_ext, rem_sub;
  logic             ge;
  logic             valid_r;
  logic [NUM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [QW-1:0]    q_r;
  side_t            side_r;

  assign trial   = {{(NUM_W + 1 - DEN_W){1'b0}}, in_den} << SHIFT;
  assign rem_ext = {1'b0, in_rem};
  assign ge      = rem_ext >= trial;
  assign rem_sub = rem_ext - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? rem_sub[NUM_W-1:0] : in_rem;
      den_r  <= in_den;
      q_r    <= {in_q[QW-2:0], ge};
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_q     = q_r;
  assign out_side  = side_r;

endmodule
